FILE: design/otq_pkg.sv
`timescale 1ns / 1ps

package otq_pkg;

	// Field widths of the request and response items
	localparam int unsigned NOW_W   = 32;
	localparam int unsigned ID_W    = 8;
	localparam int unsigned DELAY_W = 15;
	localparam int unsigned PEND_W  = 5;

	// Response codes
	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_FIRED  = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// Request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_POLL   = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [NOW_W-1:0]   now_ms;
		logic [ID_W-1:0]    callback_id;
		logic [DELAY_W-1:0] delay_ms;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   fired_id;
		logic [PEND_W-1:0] pending;
		logic              last;
	} rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctl_state_t;

endpackage

FILE: design/otq_ram.sv
`timescale 1ns / 1ps

module otq_ram #(
	parameter int unsigned WIDTH = 40,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register one read; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/one_shot_timer_event_queue.sv
`timescale 1ns / 1ps
// Insert: the response is ready in the cycle after the request transfer; one insert per
// cycle while idle and the response side does not stall. Poll: one RAM read per cycle over
// the pending entries unless an expired one waits; each firing and the done response need a
// free output register. Reset clears the pending count and all control state; the event
// store is not cleared, as only entries below the pending count are ever read.
module one_shot_timer_event_queue
	import otq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = NOW_W + ID_W;

	ctl_state_t      state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   rd_q, rd_d;
	logic [CW-1:0]   wr_q, wr_d;
	logic [NOW_W-1:0] now_q, now_d;
	logic            rsp_valid_q, rsp_valid_d;
	rsp_t            rsp_q, rsp_d;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [EW-1:0]   mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [EW-1:0]   mem_rdata;

	logic [NOW_W-1:0] rd_deadline;
	logic [ID_W-1:0]  rd_action;
	logic             slot_free;
	logic [CW-1:0]    rd_next;
	logic [CW-1:0]    remaining;

	otq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_deadline = mem_rdata[EW-1:ID_W];
	assign rd_action   = mem_rdata[ID_W-1:0];
	assign slot_free   = !rsp_valid_q || !rsp_stall;
	assign rd_next     = CW'(rd_q) + CW'(1);
	// Kept entries plus those not yet scanned
	assign remaining   = wr_q + count_q - CW'(rd_q) - CW'(1);

	// Sequence inserts and poll scans
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		now_d       = now_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		req_stall   = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = wr_q[AW-1:0];
		mem_wdata   = mem_rdata;
		mem_re      = 1'b0;
		mem_raddr   = rd_next[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				req_stall = !slot_free;
				if (req_valid && slot_free) begin
					if (req.mode == MODE_INSERT) begin
						rsp_valid_d    = 1'b1;
						rsp_d.fired_id = '0;
						rsp_d.last     = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							rsp_d.kind    = KIND_FULL;
							rsp_d.pending = PEND_W'(count_q);
						end else begin
							mem_we        = 1'b1;
							mem_waddr     = count_q[AW-1:0];
							mem_wdata     = {req.now_ms + NOW_W'(req.delay_ms), req.callback_id};
							count_d       = count_q + CW'(1);
							rsp_d.kind    = KIND_ACCEPT;
							rsp_d.pending = PEND_W'(count_q + CW'(1));
						end
					end else begin
						now_d = req.now_ms;
						wr_d  = '0;
						rd_d  = '0;
						if (count_q == '0) begin
							state_d = ST_DONE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				// Hold the entry while an expired one has nowhere to go
				if (!(rd_deadline < now_q) || slot_free) begin
					if (rd_deadline < now_q) begin
						rsp_valid_d    = 1'b1;
						rsp_d.kind     = KIND_FIRED;
						rsp_d.fired_id = rd_action;
						rsp_d.pending  = PEND_W'(remaining);
						rsp_d.last     = 1'b0;
					end else begin
						// Pack the kept entry towards the front
						mem_we = 1'b1;
						wr_d   = wr_q + CW'(1);
					end
					if (rd_next < count_q) begin
						mem_re = 1'b1;
						rd_d   = rd_next[AW-1:0];
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					rsp_valid_d    = 1'b1;
					rsp_d.kind     = KIND_DONE;
					rsp_d.fired_id = '0;
					rsp_d.pending  = PEND_W'(wr_q);
					rsp_d.last     = 1'b1;
					count_d        = wr_q;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_q        <= rd_d;
			wr_q        <= wr_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Hold the poll time and the response payload
	always_ff @(posedge clk) begin
		now_q <= now_d;
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
